>>> rtl/core/tva_pkg.sv
// Package for the tiered voice allocator: default sizes, operation codes,
// tier codes and the layout of one slot entry. No dependencies.
`default_nettype none
package tva_pkg;
   localparam int DEF_FIRST_TIER_SLOTS  = 32;
   localparam int DEF_SECOND_TIER_SLOTS = 16;
   localparam int DEF_THIRD_TIER_SLOTS  = 16;

   localparam int OP_W    = 3;
   localparam int NOTE_W  = 7;
   localparam int VEL_W   = 7;
   localparam int CHAN_W  = 8;
   localparam int PRIO_W  = 2;
   localparam int SEL_W   = 6;
   localparam int STAMP_W = 32;
   localparam int TIER_W  = 2;
   localparam int REL_W   = 7;
   localparam int CNT_W   = 7;

   localparam logic [OP_W-1:0] OP_NOTE_ON       = 3'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF      = 3'd1;
   localparam logic [OP_W-1:0] OP_ALL_NOTES_OFF = 3'd2;
   localparam logic [OP_W-1:0] OP_FREE_VOICE    = 3'd3;
   localparam logic [OP_W-1:0] OP_FREE_ALL      = 3'd4;

   localparam logic [TIER_W-1:0] TIER_FIRST  = 2'd0;
   localparam logic [TIER_W-1:0] TIER_SECOND = 2'd1;
   localparam logic [TIER_W-1:0] TIER_THIRD  = 2'd2;

   localparam logic [CHAN_W-1:0] ALL_CHANNELS     = 8'd255;
   localparam logic [PRIO_W-1:0] PRIO_UNTOUCHABLE = 2'd3;

   typedef struct packed {
      logic [NOTE_W-1:0]  note;
      logic [VEL_W-1:0]   velocity;
      logic [CHAN_W-1:0]  channel;
      logic [PRIO_W-1:0]  prio;
      logic [STAMP_W-1:0] stamp;
   } slot_entry_type;
endpackage
`default_nettype wire

>>> rtl/core/tva_slot_mem.sv
// Slot attribute memory: one write port, one read port, registered read data.
// Depends on tva_pkg for the entry layout.
`default_nettype none
module tva_slot_mem #(
   parameter int DEPTH = tva_pkg::DEF_FIRST_TIER_SLOTS + tva_pkg::DEF_SECOND_TIER_SLOTS +
                         tva_pkg::DEF_THIRD_TIER_SLOTS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                         clock,
   input  wire                         wr_en,
   input  wire  [AW-1:0]               wr_addr,
   input  wire tva_pkg::slot_entry_type wr_data,
   input  wire                         rd_en,
   input  wire  [AW-1:0]               rd_addr,
   output tva_pkg::slot_entry_type     rd_data
);
   import tva_pkg::*;

   slot_entry_type mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/tiered_voice_allocator.sv
// Top level of the tiered voice allocator: request capture, slot scan and
// grant decision around the slot memory. Depends on tva_pkg and tva_slot_mem.
`default_nettype none
// Every operation walks the slot memory one entry per cycle through its single
// read port, collecting free slots, steal candidates, note-off matches and
// active counts, then commits once the output register is free.
// One transaction is worked on at a time; the next is taken while the previous
// result still waits in the output register.
module tiered_voice_allocator #(
   parameter int FIRST_TIER_SLOTS  = tva_pkg::DEF_FIRST_TIER_SLOTS,
   parameter int SECOND_TIER_SLOTS = tva_pkg::DEF_SECOND_TIER_SLOTS,
   parameter int THIRD_TIER_SLOTS  = tva_pkg::DEF_THIRD_TIER_SLOTS
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [tva_pkg::OP_W-1:0]     req_opcode,
   input  wire  [tva_pkg::NOTE_W-1:0]   req_note,
   input  wire  [tva_pkg::VEL_W-1:0]    req_velocity,
   input  wire  [tva_pkg::CHAN_W-1:0]   req_channel,
   input  wire  [tva_pkg::PRIO_W-1:0]   req_priority_req,
   input  wire  [tva_pkg::SEL_W-1:0]    req_slot_select,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_granted,
   output logic [5:0]                   rsp_slot_granted,
   output logic [tva_pkg::TIER_W-1:0]   rsp_tier,
   output logic                         rsp_stolen,
   output logic [tva_pkg::REL_W-1:0]    rsp_release_count,
   output logic [5:0]                   rsp_first_tier_active,
   output logic [4:0]                   rsp_second_tier_active,
   output logic [4:0]                   rsp_third_tier_active,
   output logic [31:0]                  rsp_steal_total
);
   import tva_pkg::*;

   localparam int TOTAL       = FIRST_TIER_SLOTS + SECOND_TIER_SLOTS + THIRD_TIER_SLOTS;
   localparam int SECOND_BASE = FIRST_TIER_SLOTS;
   localparam int THIRD_BASE  = FIRST_TIER_SLOTS + SECOND_TIER_SLOTS;
   localparam int IW          = $clog2(TOTAL);
   localparam int RW          = $clog2(TOTAL + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [TOTAL-1:0]   active_ff, active_in;
   logic [TOTAL-1:0]   releasing_ff, releasing_in;
   logic [31:0]        seq_ff, seq_in;
   logic [31:0]        steal_ff, steal_in;

   // Captured request.
   logic [OP_W-1:0]    op_ff;
   logic [NOTE_W-1:0]  note_ff;
   logic [VEL_W-1:0]   vel_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic [PRIO_W-1:0]  prio_ff;

   // Scan pipeline.
   logic [RW-1:0]      scan_ff, scan_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]      cmp_idx_ff, cmp_idx_in;
   slot_entry_type     rd_data;
   slot_entry_type     wr_data;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;

   // Scan results.
   logic [CNT_W-1:0]   cnt_ff [3];
   logic [CNT_W-1:0]   cnt_in [3];
   logic               free_vld_ff [3];
   logic               free_vld_in [3];
   logic [IW-1:0]      free_idx_ff [3];
   logic [IW-1:0]      free_idx_in [3];
   logic               vic_vld_ff [2];
   logic               vic_vld_in [2];
   logic [IW-1:0]      vic_idx_ff [2];
   logic [IW-1:0]      vic_idx_in [2];
   logic [PRIO_W-1:0]  vic_prio_ff [2];
   logic [PRIO_W-1:0]  vic_prio_in [2];
   logic [31:0]        vic_age_ff [2];
   logic [31:0]        vic_age_in [2];
   logic [RW-1:0]      rel_ff, rel_in;

   // Grant selection.
   logic               sel_vld;
   logic [IW-1:0]      sel_idx;
   logic [1:0]         sel_tier;
   logic               sel_steal;
   logic               out_free;
   logic               req_take;

   // Scan helpers.
   logic [1:0]         cur_tier;
   logic               cur_act;
   logic [31:0]        cur_age;
   logic               cur_hit;

   assign out_free = !rsp_valid || !rsp_stall;
   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   tva_slot_mem #(.DEPTH(TOTAL), .AW(IW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (scan_ff < RW'(TOTAL)),
      .rd_addr (IW'(scan_ff)),
      .rd_data (rd_data)
   );

   // Classification of the entry that the memory returns this cycle.
   always_comb begin
      if (32'(cmp_idx_ff) < SECOND_BASE) begin
         cur_tier = 2'd0;
      end else if (32'(cmp_idx_ff) < THIRD_BASE) begin
         cur_tier = 2'd1;
      end else begin
         cur_tier = 2'd2;
      end
      cur_act = active_ff[cmp_idx_ff];
      cur_age = seq_ff - rd_data.stamp;
      if (op_ff == OP_NOTE_OFF) begin
         cur_hit = cur_act && rd_data.note == note_ff && rd_data.channel == chan_ff;
      end else if (op_ff == OP_ALL_NOTES_OFF) begin
         cur_hit = cur_act && (chan_ff == ALL_CHANNELS || rd_data.channel == chan_ff);
      end else begin
         cur_hit = 1'b0;
      end
   end

   // Grant choice: free first tier, steal first tier, free second, steal
   // second, free third.
   always_comb begin
      sel_vld   = 1'b1;
      sel_steal = 1'b0;
      sel_tier  = 2'd0;
      sel_idx   = free_idx_ff[0];
      if (free_vld_ff[0]) begin
         sel_idx = free_idx_ff[0];
      end else if (vic_vld_ff[0]) begin
         sel_idx   = vic_idx_ff[0];
         sel_steal = 1'b1;
      end else if (free_vld_ff[1]) begin
         sel_idx  = free_idx_ff[1];
         sel_tier = 2'd1;
      end else if (vic_vld_ff[1]) begin
         sel_idx   = vic_idx_ff[1];
         sel_tier  = 2'd1;
         sel_steal = 1'b1;
      end else if (free_vld_ff[2]) begin
         sel_idx  = free_idx_ff[2];
         sel_tier = 2'd2;
      end else begin
         sel_vld = 1'b0;
      end
      if (op_ff != OP_NOTE_ON) begin
         sel_vld   = 1'b0;
         sel_steal = 1'b0;
      end
   end

   assign wr_en   = (state_ff == ST_DECIDE) && out_free && sel_vld;
   assign wr_addr = sel_idx;
   always_comb begin
      wr_data.note     = note_ff;
      wr_data.velocity = vel_ff;
      wr_data.channel  = chan_ff;
      wr_data.prio     = prio_ff;
      wr_data.stamp    = seq_ff;
   end

   // Sequencer and state updates.
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      releasing_in = releasing_ff;
      seq_in       = seq_ff;
      steal_in     = steal_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = IW'(scan_ff);
      rel_in       = rel_ff;
      cnt_in       = cnt_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      vic_vld_in   = vic_vld_ff;
      vic_idx_in   = vic_idx_ff;
      vic_prio_in  = vic_prio_ff;
      vic_age_in   = vic_age_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // Free operations act on the flags before the scan counts them.
               if (req_opcode == OP_FREE_ALL) begin
                  active_in    = '0;
                  releasing_in = '0;
               end else if (req_opcode == OP_FREE_VOICE &&
                            32'(req_slot_select) < TOTAL) begin
                  active_in[IW'(req_slot_select)]    = 1'b0;
                  releasing_in[IW'(req_slot_select)] = 1'b0;
               end
               scan_in  = '0;
               rel_in   = '0;
               for (int t = 0; t < 3; t++) begin
                  cnt_in[t]      = '0;
                  free_vld_in[t] = 1'b0;
               end
               for (int t = 0; t < 2; t++) begin
                  vic_vld_in[t]  = 1'b0;
                  vic_prio_in[t] = PRIO_UNTOUCHABLE;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff < RW'(TOTAL)) begin
               cmp_vld_in = 1'b1;
               scan_in    = scan_ff + RW'(1);
            end else if (!cmp_vld_ff) begin
               state_in = ST_DECIDE;
            end
            if (cmp_vld_ff) begin
               if (cur_act) begin
                  cnt_in[cur_tier] = cnt_ff[cur_tier] + CNT_W'(1);
               end
               if (!cur_act && !free_vld_ff[cur_tier]) begin
                  free_vld_in[cur_tier] = 1'b1;
                  free_idx_in[cur_tier] = cmp_idx_ff;
               end
               // Steal candidate: lowest priority below the request, oldest wins.
               if (cur_act && cur_tier != 2'd2 && rd_data.prio < prio_ff) begin
                  if (rd_data.prio < vic_prio_ff[cur_tier[0]] ||
                      (vic_vld_ff[cur_tier[0]] && rd_data.prio == vic_prio_ff[cur_tier[0]] &&
                       cur_age > vic_age_ff[cur_tier[0]])) begin
                     vic_vld_in[cur_tier[0]]  = 1'b1;
                     vic_idx_in[cur_tier[0]]  = cmp_idx_ff;
                     vic_prio_in[cur_tier[0]] = rd_data.prio;
                     vic_age_in[cur_tier[0]]  = cur_age;
                  end
               end
               if (cur_hit) begin
                  releasing_in[cmp_idx_ff] = 1'b1;
                  rel_in = rel_ff + RW'(1);
               end
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               if (sel_vld) begin
                  active_in[sel_idx]    = 1'b1;
                  releasing_in[sel_idx] = 1'b0;
                  seq_in = seq_ff + 32'd1;
                  if (sel_steal) begin
                     steal_in = steal_ff + 32'd1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         releasing_ff <= '0;
         seq_ff       <= '0;
         steal_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         scan_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         releasing_ff <= releasing_in;
         seq_ff       <= seq_in;
         steal_ff     <= steal_in;
         cmp_vld_ff   <= cmp_vld_in;
         scan_ff      <= scan_in;
      end
   end

   // Request capture and scan accumulators.
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_opcode;
         note_ff <= req_note;
         vel_ff  <= req_velocity;
         chan_ff <= req_channel;
         prio_ff <= req_priority_req;
      end
      cmp_idx_ff  <= cmp_idx_in;
      rel_ff      <= rel_in;
      cnt_ff      <= cnt_in;
      free_vld_ff <= free_vld_in;
      free_idx_ff <= free_idx_in;
      vic_vld_ff  <= vic_vld_in;
      vic_idx_ff  <= vic_idx_in;
      vic_prio_ff <= vic_prio_in;
      vic_age_ff  <= vic_age_in;
   end

   // Result transaction register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (state_ff == ST_DECIDE && out_free) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE && out_free) begin
         rsp_granted       <= sel_vld;
         rsp_slot_granted  <= sel_vld ? 6'(sel_idx) : 6'd0;
         rsp_tier          <= sel_vld ? sel_tier : TIER_FIRST;
         rsp_stolen        <= sel_steal;
         rsp_release_count <= REL_W'(rel_ff);
         rsp_first_tier_active <= 6'(cnt_ff[0] +
            CNT_W'(sel_vld && !sel_steal && sel_tier == TIER_FIRST));
         rsp_second_tier_active <= 5'(cnt_ff[1] +
            CNT_W'(sel_vld && !sel_steal && sel_tier == TIER_SECOND));
         rsp_third_tier_active <= 5'(cnt_ff[2] +
            CNT_W'(sel_vld && !sel_steal && sel_tier == TIER_THIRD));
         rsp_steal_total   <= steal_ff + 32'(sel_steal);
      end
   end
endmodule
`default_nettype wire

>>> sim/tva_checker.sv
// Checker for the tiered voice allocator: watches both channels, keeps its own
// copy of the slot state and compares every result. Depends on tva_pkg.
module tva_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [6:0]  req_note,
   input  logic [6:0]  req_velocity,
   input  logic [7:0]  req_channel,
   input  logic [1:0]  req_priority_req,
   input  logic [5:0]  req_slot_select,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_granted,
   input  logic [5:0]  rsp_slot_granted,
   input  logic [1:0]  rsp_tier,
   input  logic        rsp_stolen,
   input  logic [6:0]  rsp_release_count,
   input  logic [5:0]  rsp_first_tier_active,
   input  logic [4:0]  rsp_second_tier_active,
   input  logic [4:0]  rsp_third_tier_active,
   input  logic [31:0] rsp_steal_total,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tva_pkg::*;

   localparam int N1 = DEF_FIRST_TIER_SLOTS;
   localparam int N2 = DEF_SECOND_TIER_SLOTS;
   localparam int N3 = DEF_THIRD_TIER_SLOTS;
   localparam int NSLOT = N1 + N2 + N3;

   typedef struct packed {
      logic        granted;
      logic [5:0]  slot;
      logic [1:0]  tier;
      logic        stolen;
      logic [6:0]  released;
      logic [5:0]  first_cnt;
      logic [4:0]  second_cnt;
      logic [4:0]  third_cnt;
      logic [31:0] steals;
   } alloc_result_type;

   // Shadow of the allocator's slot state.
   bit          voice_on [NSLOT];
   bit          voice_rel [NSLOT];
   logic [6:0]  voice_note [NSLOT];
   logic [7:0]  voice_chan [NSLOT];
   logic [1:0]  voice_prio [NSLOT];
   logic [31:0] voice_stamp [NSLOT];
   logic [31:0] grant_seq;
   logic [31:0] steal_cnt;
   alloc_result_type expected_results[$];

   assign pending_count = expected_results.size();

   function automatic int find_free(int base, int n);
      for (int i = 0; i < n; i++)
         if (!voice_on[base+i]) return base + i;
      return -1;
   endfunction

   // Lowest priority below the request; ties go to the oldest grant.
   function automatic int find_victim(int base, int n, logic [1:0] prio);
      int best;
      logic [1:0] lowest;
      logic [31:0] age_s, age_b;
      best = -1;
      lowest = PRIO_UNTOUCHABLE;
      for (int i = 0; i < n; i++) begin
         int s;
         s = base + i;
         if (!voice_on[s] || voice_prio[s] >= prio) continue;
         age_s = grant_seq - voice_stamp[s];
         if (best >= 0) age_b = grant_seq - voice_stamp[best];
         if (voice_prio[s] < lowest ||
             (best >= 0 && voice_prio[s] == lowest && age_s > age_b)) begin
            best = s;
            lowest = voice_prio[s];
         end
      end
      return best;
   endfunction

   function automatic int count_on(int base, int n);
      int c;
      c = 0;
      for (int i = 0; i < n; i++) c += voice_on[base+i];
      return c;
   endfunction

   function automatic alloc_result_type allocate_voice(logic [2:0] op, logic [6:0] note,
         logic [6:0] vel, logic [7:0] chan, logic [1:0] prio, logic [5:0] sel);
      alloc_result_type r;
      int s, rel;
      bit steal;
      logic [1:0] tr;
      r = '0;
      rel = 0;
      if (op == OP_NOTE_ON) begin
         steal = 0;
         tr = TIER_FIRST;
         s = find_free(0, N1);
         if (s < 0) begin s = find_victim(0, N1, prio); steal = s >= 0; end
         if (s < 0) begin
            tr = TIER_SECOND;
            s = find_free(N1, N2);
            if (s < 0) begin s = find_victim(N1, N2, prio); steal = s >= 0; end
         end
         if (s < 0) begin
            tr = TIER_THIRD;
            s = find_free(N1 + N2, N3);
         end
         if (s >= 0) begin
            voice_note[s] = note;
            voice_chan[s] = chan;
            voice_prio[s] = prio;
            voice_stamp[s] = grant_seq;
            grant_seq++;
            voice_on[s] = 1;
            voice_rel[s] = 0;
            if (steal) steal_cnt++;
            r.granted = 1;
            r.slot = s[5:0];
            r.tier = tr;
            r.stolen = steal;
         end
      end else if (op == OP_NOTE_OFF || op == OP_ALL_NOTES_OFF) begin
         for (int i = 0; i < NSLOT; i++) begin
            bit hit;
            if (!voice_on[i]) continue;
            if (op == OP_NOTE_OFF) hit = voice_note[i] == note && voice_chan[i] == chan;
            else hit = chan == ALL_CHANNELS || voice_chan[i] == chan;
            if (hit) begin
               voice_rel[i] = 1;
               rel++;
            end
         end
      end else if (op == OP_FREE_VOICE) begin
         if (sel < NSLOT && voice_on[sel]) begin
            voice_on[sel] = 0;
            voice_rel[sel] = 0;
         end
      end else if (op == OP_FREE_ALL) begin
         for (int i = 0; i < NSLOT; i++) begin
            voice_on[i] = 0;
            voice_rel[i] = 0;
         end
      end
      r.released = rel[6:0];
      r.first_cnt = 6'(count_on(0, N1));
      r.second_cnt = 5'(count_on(N1, N2));
      r.third_cnt = 5'(count_on(N1 + N2, N3));
      r.steals = steal_cnt;
      return r;
   endfunction

   // Predict on each accepted request, compare on each accepted result.
   always @(posedge clock) begin
      alloc_result_type got, want;
      if (reset) begin
         for (int i = 0; i < NSLOT; i++) begin
            voice_on[i] = 0;
            voice_rel[i] = 0;
         end
         grant_seq = 0;
         steal_cnt = 0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_results.insert(expected_results.size(),
               allocate_voice(req_opcode, req_note, req_velocity,
                              req_channel, req_priority_req, req_slot_select));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_granted, rsp_slot_granted, rsp_tier, rsp_stolen, rsp_release_count,
                    rsp_first_tier_active, rsp_second_tier_active, rsp_third_tier_active,
                    rsp_steal_total};
            if (expected_results.size() == 0) begin
               $display("%0t: result with no transaction outstanding: %h", $time, got);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.granted !== want.granted || got.slot !== want.slot ||
                   got.tier !== want.tier || got.stolen !== want.stolen ||
                   got.released !== want.released || got.first_cnt !== want.first_cnt ||
                   got.second_cnt !== want.second_cnt || got.third_cnt !== want.third_cnt ||
                   got.steals !== want.steals) begin
                  $display("%0t: mismatch expected g=%0d s=%0d t=%0d st=%0d rel=%0d %s",
                     $time, want.granted, want.slot, want.tier, want.stolen, want.released,
                     $sformatf("cnt=%0d/%0d/%0d tot=%0d",
                        want.first_cnt, want.second_cnt, want.third_cnt, want.steals));
                  $display("%0t:          actual   g=%0d s=%0d t=%0d st=%0d rel=%0d %s",
                     $time, got.granted, got.slot, got.tier, got.stolen, got.released,
                     $sformatf("cnt=%0d/%0d/%0d tot=%0d",
                        got.first_cnt, got.second_cnt, got.third_cnt, got.steals));
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

>>> sim/tb_top.sv
// Testbench top for the tiered voice allocator: clock, reset, request
// stimulus, result stall pattern and verdict. Depends on tva_pkg and tva_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tva_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_opcode = '0;
   logic [6:0]  req_note = '0;
   logic [6:0]  req_velocity = '0;
   logic [7:0]  req_channel = '0;
   logic [1:0]  req_priority_req = '0;
   logic [5:0]  req_slot_select = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_granted;
   logic [5:0]  rsp_slot_granted;
   logic [1:0]  rsp_tier;
   logic        rsp_stolen;
   logic [6:0]  rsp_release_count;
   logic [5:0]  rsp_first_tier_active;
   logic [4:0]  rsp_second_tier_active;
   logic [4:0]  rsp_third_tier_active;
   logic [31:0] rsp_steal_total;
   int          fail_count;
   int          pending_count;
   bit          quiet_phase = 0;
   bit          hold_results = 0;
   int          idle_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   tiered_voice_allocator u_top (.*);

   tva_checker u_checker (.*);

   // Result side: random stall bursts, a long hold on request, none at the end.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_stall <= 1;
            for (int i = 0; i < 300; i++) @(posedge clock);
            rsp_stall <= 0;
            hold_results = 0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Offer one transaction and hold it until it is accepted.
   task automatic send_op(logic [2:0] op, logic [6:0] note, logic [6:0] vel,
                          logic [7:0] chan, logic [1:0] prio, logic [5:0] sel);
      req_valid <= 1;
      req_opcode <= op;
      req_note <= note;
      req_velocity <= vel;
      req_channel <= chan;
      req_priority_req <= prio;
      req_slot_select <= sel;
      do @(posedge clock); while (req_stall);
   endtask

   // Occasional sender gap between transactions, with valid held low in the gap.
   task automatic maybe_gap();
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Random item weighted toward note-ons over a small note and channel set.
   task automatic random_op();
      int pick;
      logic [2:0] op;
      logic [7:0] chan;
      pick = $urandom_range(0, 99);
      if (pick < 55) op = OP_NOTE_ON;
      else if (pick < 72) op = OP_NOTE_OFF;
      else if (pick < 80) op = OP_ALL_NOTES_OFF;
      else if (pick < 94) op = OP_FREE_VOICE;
      else if (pick < 97) op = OP_FREE_ALL;
      else op = 3'($urandom_range(5, 7));
      chan = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      if (op == OP_ALL_NOTES_OFF && $urandom_range(0, 5) == 0) chan = ALL_CHANNELS;
      send_op(op, ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(60, 67)),
              7'($urandom), chan, 2'($urandom), 6'($urandom));
      maybe_gap();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: fill all tiers, steal, untouchable, release and free cases.
      for (int i = 0; i < 8; i++) send_op(OP_NOTE_ON, 7'(i), 7'd127, 8'd0, 2'd1, 6'd0);
      send_op(OP_NOTE_OFF, 7'd3, 7'd0, 8'd0, 2'd0, 6'd0);
      send_op(OP_NOTE_OFF, 7'd3, 7'd0, 8'd0, 2'd0, 6'd0);
      send_op(OP_ALL_NOTES_OFF, 7'd0, 7'd0, ALL_CHANNELS, 2'd0, 6'd0);
      send_op(OP_FREE_VOICE, 7'd0, 7'd0, 8'd0, 2'd0, 6'd63);
      send_op(OP_FREE_VOICE, 7'd0, 7'd0, 8'd0, 2'd0, 6'd2);
      send_op(OP_FREE_VOICE, 7'd0, 7'd0, 8'd0, 2'd0, 6'd2);
      send_op(3'd7, 7'd127, 7'd127, 8'd255, 2'd3, 6'd63);
      send_op(OP_FREE_ALL, 7'd0, 7'd0, 8'd0, 2'd0, 6'd0);
      // Fill every slot with mixed priorities, then steal and overflow.
      for (int i = 0; i < 64; i++)
         send_op(OP_NOTE_ON, 7'(i), 7'(i), 8'(i % 4), 2'(i % 4), 6'd0);
      send_op(OP_NOTE_ON, 7'd127, 7'd0, 8'd255, 2'd0, 6'd0);
      for (int i = 0; i < 28; i++)
         send_op(OP_NOTE_ON, 7'd100, 7'd1, 8'd9, 2'(1 + i % 3), 6'd0);
      send_op(OP_NOTE_OFF, 7'd100, 7'd0, 8'd9, 2'd0, 6'd0);
      send_op(OP_ALL_NOTES_OFF, 7'd0, 7'd0, 8'd2, 2'd0, 6'd0);
      drain();

      // Long receiver hold while requests keep coming.
      hold_results = 1;
      for (int i = 0; i < 10; i++) random_op();
      drain();
      send_op(OP_FREE_ALL, 7'd0, 7'd0, 8'd0, 2'd0, 6'd0);

      // Random part, with periodic full drains.
      for (int i = 0; i < 330; i++) begin
         if (i % 90 == 89) drain();
         if (i == 290) quiet_phase = 1;
         random_op();
      end
      drain();
      repeat (150) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

>>> sim.f
rtl/core/tva_pkg.sv
rtl/core/tva_slot_mem.sv
rtl/core/tiered_voice_allocator.sv
sim/tva_checker.sv
sim/tb_top.sv
